>>> hw/rtl/preemptive_priority_table_macros.svh
// Assertion shorthands used by the checker file.
`ifndef PREEMPTIVE_PRIORITY_TABLE_MACROS_SVH
`define PREEMPTIVE_PRIORITY_TABLE_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define PPT_CHECK(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define PPT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

>>> hw/rtl/ppt_pkg.sv
package ppt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int CLIENT_W    = 8;
    localparam int PRIO_W      = 8;
    localparam int STATUS_W    = 2;

    localparam logic FUNC_SUBSCRIBE   = 1'b0;
    localparam logic FUNC_UNSUBSCRIBE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic                used;
        logic                visited;
        logic [CLIENT_W-1:0] client;
        logic [PRIO_W-1:0]   prio;
    } entry_t;

    typedef struct packed {
        logic                append;
        logic                pop;
        logic                push;
        logic                clr_visit;
        logic [CLIENT_W-1:0] client;
        logic [PRIO_W-1:0]   prio;
    } cell_ctrl_t;

endpackage

>>> hw/rtl/ppt_req_if.sv
interface ppt_req_if import ppt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                func;
    logic [CLIENT_W-1:0] client_id;
    logic [PRIO_W-1:0]   priority_req;

    modport source (output valid, func, client_id, priority_req, input ready);
    modport sink (input valid, func, client_id, priority_req, output ready);
endinterface

>>> hw/rtl/ppt_res_if.sv
interface ppt_res_if import ppt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                run_valid;
    logic [CLIENT_W-1:0] run_client;
    logic                preempt_valid;
    logic [CLIENT_W-1:0] preempt_client;
    logic [STATUS_W-1:0] status;

    modport source (output valid, run_valid, run_client, preempt_valid, preempt_client,
                    status, input ready);
    modport sink (input valid, run_valid, run_client, preempt_valid, preempt_client,
                  status, output ready);
endinterface

>>> hw/rtl/ppt_cell.sv
module ppt_cell import ppt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       prev_used,
    input  entry_t     next_entry,
    output entry_t     entry
);

    logic                used_reg, used_next;
    logic                visited_reg, visited_next;
    logic [CLIENT_W-1:0] client_reg, client_next;
    logic [PRIO_W-1:0]   prio_reg, prio_next;

    always_comb
    begin
        used_next    = used_reg;
        visited_next = visited_reg;
        client_next  = client_reg;
        prio_next    = prio_reg;
        if (ctrl.append)
        begin
            // Only the first free cell takes the new request.
            if (!used_reg && prev_used)
            begin
                used_next    = 1'b1;
                visited_next = 1'b0;
                client_next  = ctrl.client;
                prio_next    = ctrl.prio;
            end
        end
        else if (ctrl.pop)
        begin
            if (next_entry.used)
            begin
                used_next    = 1'b1;
                visited_next = next_entry.visited;
                client_next  = next_entry.client;
                prio_next    = next_entry.prio;
            end
            else if (used_reg && ctrl.push)
            begin
                // Last used cell: after the shift it is the tail, where the head re-enters.
                used_next    = 1'b1;
                visited_next = 1'b1;
                client_next  = ctrl.client;
                prio_next    = ctrl.prio;
            end
            else
            begin
                used_next    = 1'b0;
                visited_next = 1'b0;
            end
        end
        else if (ctrl.clr_visit)
        begin
            visited_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= 1'b0;
            visited_reg <= 1'b0;
        end
        else
        begin
            used_reg    <= used_next;
            visited_reg <= visited_next;
        end
    end

    always_ff @(posedge clk)
    begin
        client_reg <= client_next;
        prio_reg   <= prio_next;
    end

    assign entry = '{used: used_reg, visited: visited_reg, client: client_reg, prio: prio_reg};

endmodule

>>> hw/rtl/preemptive_priority_table.sv
// Preemptive priority table: a row of TABLE_DEPTH cells holds the subscribed clients in
// arrival order. Each request is handled alone. A subscribe that finds a free cell first
// writes the new client into the first free cell, then every request rotates the used
// entries once through the head of the row, one entry per cycle, where a comparator finds
// the first entry of greatest priority and an unsubscribe drops its first matching entry,
// which closes the gap. The result is registered once the rotation ends and the result
// register is free; the next request can be accepted as soon as it is, even while it waits
// to be taken.
module preemptive_priority_table import ppt_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    ppt_req_if.sink  request,
    ppt_res_if.source result
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_APPEND = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic                func_reg, func_next;
    logic [CLIENT_W-1:0] id_reg, id_next;
    logic [PRIO_W-1:0]   prio_reg, prio_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                found_reg, found_next;
    logic                top_present_reg, top_present_next;
    logic [CLIENT_W-1:0] top_client_reg, top_client_next;
    logic [PRIO_W-1:0]   top_level_reg, top_level_next;
    logic                runner_present_reg, runner_present_next;
    logic [CLIENT_W-1:0] runner_client_reg, runner_client_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_run_valid_reg, out_run_valid_next;
    logic [CLIENT_W-1:0] out_run_client_reg, out_run_client_next;
    logic                out_pre_valid_reg, out_pre_valid_next;
    logic [CLIENT_W-1:0] out_pre_client_reg, out_pre_client_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    cell_ctrl_t ctrl;
    entry_t     cells [TABLE_DEPTH];
    entry_t     head;
    logic       scan_end;
    logic       drop;
    logic       new_grant;
    logic       out_free;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            logic   prev_used;
            entry_t next_entry;
            if (gi == 0)
            begin : g_first
                assign prev_used = 1'b1;
            end
            else
            begin : g_prev
                assign prev_used = cells[gi-1].used;
            end
            if (gi == TABLE_DEPTH - 1)
            begin : g_last
                assign next_entry = '0;
            end
            else
            begin : g_next
                assign next_entry = cells[gi+1];
            end
            ppt_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .prev_used  (prev_used),
                .next_entry (next_entry),
                .entry      (cells[gi])
            );
        end
    endgenerate

    assign head     = cells[0];
    assign scan_end = !head.used || head.visited;
    assign drop     = (func_reg == FUNC_UNSUBSCRIBE) && !found_reg && (head.client == id_reg);
    assign new_grant = top_present_reg &&
                       (!runner_present_reg || (top_client_reg != runner_client_reg));
    assign out_free = !out_valid_reg || result.ready;

    assign request.ready = (state_reg == S_IDLE);

    always_comb
    begin
        ctrl                = '0;
        state_next          = state_reg;
        func_next           = func_reg;
        id_next             = id_reg;
        prio_next           = prio_reg;
        status_next         = status_reg;
        found_next          = found_reg;
        top_present_next    = top_present_reg;
        top_client_next     = top_client_reg;
        top_level_next      = top_level_reg;
        runner_present_next = runner_present_reg;
        runner_client_next  = runner_client_reg;
        out_valid_next      = out_valid_reg && !result.ready;
        out_run_valid_next  = out_run_valid_reg;
        out_run_client_next = out_run_client_reg;
        out_pre_valid_next  = out_pre_valid_reg;
        out_pre_client_next = out_pre_client_reg;
        out_status_next     = out_status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    func_next        = request.func;
                    id_next          = request.client_id;
                    prio_next        = request.priority_req;
                    status_next      = STATUS_OK;
                    found_next       = 1'b0;
                    top_present_next = 1'b0;
                    top_client_next  = '0;
                    top_level_next   = '0;
                    state_next       = S_SCAN;
                    if (request.func == FUNC_SUBSCRIBE)
                    begin
                        if (cells[TABLE_DEPTH-1].used)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            state_next = S_APPEND;
                        end
                    end
                end
            end
            S_APPEND:
            begin
                ctrl.append = 1'b1;
                ctrl.client = id_reg;
                ctrl.prio   = prio_reg;
                state_next  = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    ctrl.pop    = 1'b1;
                    ctrl.push   = !drop;
                    ctrl.client = head.client;
                    ctrl.prio   = head.prio;
                    if (drop)
                    begin
                        found_next = 1'b1;
                        // Removing the runner takes its grant away without a preemption.
                        if (runner_present_reg && (runner_client_reg == id_reg))
                        begin
                            runner_present_next = 1'b0;
                            runner_client_next  = '0;
                        end
                    end
                    else if (!top_present_reg || (head.prio > top_level_reg))
                    begin
                        top_present_next = 1'b1;
                        top_client_next  = head.client;
                        top_level_next   = head.prio;
                    end
                end
            end
            S_FINISH:
            begin
                ctrl.clr_visit = 1'b1;
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_pre_valid_next  = new_grant && runner_present_reg;
                    out_pre_client_next = (new_grant && runner_present_reg) ?
                                          runner_client_reg : '0;
                    out_status_next     = ((func_reg == FUNC_UNSUBSCRIBE) && !found_reg) ?
                                          STATUS_NOT_FOUND : status_reg;
                    if (new_grant)
                    begin
                        runner_present_next = 1'b1;
                        runner_client_next  = top_client_reg;
                        out_run_valid_next  = 1'b1;
                        out_run_client_next = top_client_reg;
                    end
                    else
                    begin
                        out_run_valid_next  = runner_present_reg;
                        out_run_client_next = runner_present_reg ? runner_client_reg : '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            found_reg          <= 1'b0;
            top_present_reg    <= 1'b0;
            top_client_reg     <= '0;
            top_level_reg      <= '0;
            runner_present_reg <= 1'b0;
            runner_client_reg  <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            found_reg          <= found_next;
            top_present_reg    <= top_present_next;
            top_client_reg     <= top_client_next;
            top_level_reg      <= top_level_next;
            runner_present_reg <= runner_present_next;
            runner_client_reg  <= runner_client_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg           <= func_next;
        id_reg             <= id_next;
        prio_reg           <= prio_next;
        status_reg         <= status_next;
        out_run_valid_reg  <= out_run_valid_next;
        out_run_client_reg <= out_run_client_next;
        out_pre_valid_reg  <= out_pre_valid_next;
        out_pre_client_reg <= out_pre_client_next;
        out_status_reg     <= out_status_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.run_valid      = out_run_valid_reg;
    assign result.run_client     = out_run_client_reg;
    assign result.preempt_valid  = out_pre_valid_reg;
    assign result.preempt_client = out_pre_client_reg;
    assign result.status         = out_status_reg;

endmodule

>>> hw/rtl/ppt_checker.sv
`include "preemptive_priority_table_macros.svh"

module ppt_checker import ppt_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                res_valid,
    input logic                res_ready,
    input logic                run_valid,
    input logic [CLIENT_W-1:0] run_client,
    input logic                preempt_valid,
    input logic [CLIENT_W-1:0] preempt_client
);

    // A preemption always hands the grant to some other client.
    `PPT_CHECK(a_preempt_has_runner, !res_valid || !preempt_valid || (run_valid && (run_client != preempt_client)), "preemption without a different runner")

    // Client fields read zero when their flag is low.
    `PPT_CHECK(a_idle_fields_zero, !res_valid || ((run_valid || (run_client == '0)) && (preempt_valid || (preempt_client == '0))), "client field set while its flag is low")

    // One request is worked on at a time.
    `PPT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request accepted while busy")

    // A stalled result holds.
    `PPT_NEXT(a_result_holds, res_valid && !res_ready, res_valid && $stable(run_client) && $stable(preempt_client), "stalled result changed")

endmodule

bind preemptive_priority_table ppt_checker u_ppt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (request.valid),
    .req_ready      (request.ready),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .run_valid      (result.run_valid),
    .run_client     (result.run_client),
    .preempt_valid  (result.preempt_valid),
    .preempt_client (result.preempt_client)
);
